>>> design/bfs_pkg.sv
// Shared types and codes for the breadth-first search unit.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
package bfs_pkg;

  // Item kinds on the request channel.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // Status codes on the response channel.
  localparam logic [1:0] STATUS_VISIT   = 2'd0;
  localparam logic [1:0] STATUS_STORED  = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;
  localparam logic [1:0] STATUS_CLEARED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;        // capture the accepted request item
    logic       clear;        // empty lists, visited marks and counters
    logic       head_rd;      // read the list head of the latched source
    logic       add_write;    // store the new edge and move the list head
    logic       fifo_init;    // mark and enqueue the start vertex
    logic       fifo_rd;      // read the visit queue at its head
    logic       cur_load;     // take the dequeued vertex, read its list head
    logic       edge_load;    // start the edge walk from the list head
    logic       edge_rd;      // read the current edge entry
    logic       edge_step;    // visit the edge target, follow the link
    logic       push;         // load the output register
    logic       push_visit;   // the pushed result is a visited vertex
    logic [1:0] push_status;  // status of a non-visit result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;        // kind of the latched item
    logic       src_ok;      // latched source vertex is in range
    logic       add_ok;      // edge can be stored
    logic       fifo_empty;  // visit queue holds no vertex
    logic       e_valid;     // current edge pointer names a stored edge
    logic       out_free;    // output register can take a result
  } stat_t;

endpackage

>>> design/bfs_req_if.sv
// Request channel of the breadth-first search unit.
// Carries valid, ready and one request item; no package dependency.
interface bfs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] from_vertex;
  logic [4:0] to_vertex;

  modport source (output valid, kind, from_vertex, to_vertex, input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

>>> design/bfs_rsp_if.sv
// Response channel of the breadth-first search unit.
// Carries valid, ready and one result item; no package dependency.
interface bfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] vertex;
  logic       last;

  modport source (output valid, status, vertex, last, input ready);
  modport sink (input valid, status, vertex, last, output ready);
endinterface

>>> design/bfs_ctrl.sv
// Sequencer of the breadth-first search unit.
// Drives bfs_pkg::cmd_t commands from bfs_pkg::stat_t status; depends on bfs_pkg.
module bfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bfs_pkg::stat_t stat,
  output bfs_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_ADD_RD,
    S_ADD_WR,
    S_RESP,
    S_INIT,
    S_POP,
    S_CUR,
    S_HEAD,
    S_EREQ,
    S_EDATA,
    S_EMIT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] resp_status;
  logic [1:0] resp_status_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd              = '0;
    state_next       = state;
    resp_status_next = resp_status;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          bfs_pkg::KIND_CLEAR: state_next = S_CLEAR;
          bfs_pkg::KIND_ADD: begin
            if (stat.add_ok) begin
              state_next = S_ADD_RD;
            end else begin
              resp_status_next = bfs_pkg::STATUS_DROPPED;
              state_next       = S_RESP;
            end
          end
          bfs_pkg::KIND_SEARCH: state_next = stat.src_ok ? S_INIT : S_IDLE;
          default: state_next = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        if (stat.out_free) begin
          cmd.clear       = 1'b1;
          cmd.push        = 1'b1;
          cmd.push_status = bfs_pkg::STATUS_CLEARED;
          state_next      = S_IDLE;
        end
      end
      S_ADD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_write    = 1'b1;
        resp_status_next = bfs_pkg::STATUS_STORED;
        state_next       = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_status = resp_status;
          state_next      = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.fifo_init = 1'b1;
        state_next    = S_POP;
      end
      S_POP: begin
        cmd.fifo_rd = 1'b1;
        state_next  = S_CUR;
      end
      S_CUR: begin
        cmd.cur_load = 1'b1;
        state_next   = S_HEAD;
      end
      S_HEAD: begin
        cmd.edge_load = 1'b1;
        state_next    = S_EREQ;
      end
      S_EREQ: begin
        if (stat.e_valid) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_EDATA;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EDATA: begin
        cmd.edge_step = 1'b1;
        state_next    = S_EREQ;
      end
      S_EMIT: begin
        // A vertex goes out once its edges are walked, so an empty queue
        // at this point means it is the final result of the search.
        if (stat.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_visit  = 1'b1;
          cmd.push_status = bfs_pkg::STATUS_VISIT;
          state_next      = stat.fifo_empty ? S_IDLE : S_POP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and the pending response code.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= bfs_pkg::STATUS_CLEARED;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
    end
  end

`ifndef ASSERT_OFF
  // The walk only reads edges that the datapath reports as stored.
  a_edge_rd_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_rd |-> stat.e_valid)
    else $error("edge read issued on an invalid edge pointer");

  // An add reaches the write step only after the room and range check passed.
  a_add_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_RD) |-> $past(stat.add_ok))
    else $error("edge store entered without a passing check");

  // A request item, once taken, moves on to decode.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_DECODE))
    else $error("accepted item did not move to decode");
`endif

endmodule

>>> design/bfs_dp.sv
// Datapath of the breadth-first search unit: list heads, edge store,
// visit queue, visited marks and the output register. Depends on bfs_pkg.
module bfs_dp #(
  parameter int VERTICES = 32,
  parameter int EDGES    = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  bfs_pkg::cmd_t  cmd,
  output bfs_pkg::stat_t stat,
  input  logic [1:0]     kind,
  input  logic [4:0]     from_vertex,
  input  logic [4:0]     to_vertex,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output logic [1:0]     rsp_status,
  output logic [4:0]     rsp_vertex,
  output logic           rsp_last
);

  localparam int VIW = $clog2(VERTICES);
  localparam int CW  = $clog2(VERTICES + 1);
  localparam int EW  = $clog2(EDGES + 1);
  localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int WW  = EW + 5;
  localparam logic [EW-1:0] EMPTY = EW'(EDGES);

  // Latched request item.
  logic [1:0] kind_q;
  logic [4:0] src_q;
  logic [4:0] dst_q;

  // Control state.
  logic [VERTICES-1:0] visited;
  logic [VERTICES-1:0] head_valid;
  logic [EW-1:0]       edges_used;
  logic [CW-1:0]       fifo_head;
  logic [CW-1:0]       fifo_tail;
  logic                out_valid;

  // Working registers and memory read data.
  logic [4:0]    cur;
  logic [EW-1:0] e;
  logic [EW-1:0] head_q;
  logic          head_hit;
  logic [4:0]    fifo_q;
  logic [WW-1:0] edge_q;

  // Memories.
  logic [EW-1:0] head_mem [VERTICES];
  logic [WW-1:0] edge_mem [EDGES];
  logic [4:0]    fifo_mem [VERTICES];

  logic [6:0]     src_wide;
  logic [6:0]     dst_wide;
  logic [6:0]     fifo_wide;
  logic [6:0]     tgt_wide;
  logic [VIW-1:0] src_idx;
  logic [VIW-1:0] head_rd_idx;
  logic [VIW-1:0] tgt_idx;
  logic [4:0]     tgt;
  logic [EW-1:0]  link;
  logic [EW-1:0]  head_link;
  logic           src_ok;
  logic           dst_ok;
  logic           out_free;
  logic           tgt_new;

  // Vertex numbers widened, range checked and cut to the index width.
  assign src_wide    = {2'b00, src_q};
  assign dst_wide    = {2'b00, dst_q};
  assign fifo_wide   = {2'b00, fifo_q};
  assign tgt         = edge_q[4:0];
  assign link        = edge_q[WW-1:5];
  assign tgt_wide    = {2'b00, tgt};
  assign src_idx     = src_wide[VIW-1:0];
  assign tgt_idx     = tgt_wide[VIW-1:0];
  assign head_rd_idx = cmd.cur_load ? fifo_wide[VIW-1:0] : src_idx;
  assign src_ok      = (src_wide < 7'(VERTICES));
  assign dst_ok      = (dst_wide < 7'(VERTICES));
  assign head_link   = head_hit ? head_q : EMPTY;
  assign tgt_new     = !visited[tgt_idx];
  assign out_free    = !out_valid || rsp_ready;

  assign stat.kind       = kind_q;
  assign stat.src_ok     = src_ok;
  assign stat.add_ok     = src_ok && dst_ok && (edges_used < EMPTY);
  assign stat.fifo_empty = (fifo_head == fifo_tail);
  assign stat.e_valid    = (e < edges_used);
  assign stat.out_free   = out_free;

  // Request item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      src_q  <= from_vertex;
      dst_q  <= to_vertex;
    end
  end

  // List head memory; entries without a valid bit read as the empty marker.
  always_ff @(posedge clk) begin
    if (cmd.head_rd || cmd.cur_load) begin
      head_q   <= head_mem[head_rd_idx];
      head_hit <= head_valid[head_rd_idx];
    end
    if (cmd.add_write) begin
      head_mem[src_idx] <= edges_used;
    end
  end

  // Edge store: each entry holds the link to the next edge and the target.
  always_ff @(posedge clk) begin
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[e[EAW-1:0]];
    end
    if (cmd.add_write) begin
      edge_mem[edges_used[EAW-1:0]] <= {head_link, dst_q};
    end
  end

  // Visit queue memory.
  always_ff @(posedge clk) begin
    if (cmd.fifo_rd) begin
      fifo_q <= fifo_mem[fifo_head[VIW-1:0]];
    end
    if (cmd.fifo_init) begin
      fifo_mem[VIW'(0)] <= src_q;
    end else if (cmd.edge_step && tgt_new) begin
      fifo_mem[fifo_tail[VIW-1:0]] <= tgt;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur <= fifo_q;
    end
    if (cmd.edge_load) begin
      e <= head_link;
    end else if (cmd.edge_step) begin
      e <= link;
    end
  end

  // Marks, valid bits and counters.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      visited    <= '0;
      head_valid <= '0;
      edges_used <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
    end else begin
      if (cmd.add_write) begin
        head_valid[src_idx] <= 1'b1;
        edges_used          <= edges_used + EW'(1);
      end
      if (cmd.fifo_init) begin
        visited[src_idx] <= 1'b1;
        fifo_head        <= '0;
        fifo_tail        <= CW'(1);
      end
      if (cmd.cur_load) begin
        fifo_head <= fifo_head + CW'(1);
      end
      if (cmd.edge_step && tgt_new) begin
        visited[tgt_idx] <= 1'b1;
        fifo_tail        <= fifo_tail + CW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp_status <= cmd.push_visit ? bfs_pkg::STATUS_VISIT : cmd.push_status;
      rsp_vertex <= cmd.push_visit ? cur : 5'd0;
      rsp_last   <= cmd.push_visit ? (fifo_head == fifo_tail) : 1'b1;
    end
  end

  assign rsp_valid = out_valid;

`ifndef ASSERT_OFF
  // The queue never holds more vertices than the graph has.
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_tail <= CW'(VERTICES))
    else $error("visit queue tail beyond vertex count");

  // The queue head never passes its tail.
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    fifo_head <= fifo_tail)
    else $error("visit queue head passed tail");

  // The edge count stays within the store.
  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    edges_used <= EMPTY)
    else $error("edge count beyond store size");

  // A result is loaded only when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> out_free)
    else $error("result pushed over a waiting result");
`endif

endmodule

>>> design/graph_breadth_first_search_unit.sv
// Breadth-first search unit over a directed graph held as edge lists.
// Request channel req: kind (clear, add edge, search), from_vertex, to_vertex.
// Response channel rsp: status, vertex, last; last marks the final result
// of each request item. One request item is in work at a time.
// Sequence: a clear or a dropped add loads its single result after decode,
// a stored add after its list head read and edge write; the next item is
// accepted only once the last result of the item before is loaded. A search
// marks and enqueues its start vertex, then for each vertex pops the queue,
// loads the vertex and reads its list head, starts the edge walk, reads and
// visits each edge in turn and emits the vertex. The edge store, the list
// heads and the visit queue each give one registered read per cycle. Search
// results leave in breadth-first order, each vertex once its edge list is
// walked. A search from an out-of-range vertex, and kind 3, give no result.
// Reset (rst, synchronous) empties all lists, the visited marks and the
// edge count at once; no clearing pass is needed.
// When rsp stalls, the result waits in the output register; the walk goes on
// until its next result is ready and then waits, and req stays not ready
// until the item's last result is loaded.
module graph_breadth_first_search_unit #(
  parameter int VERTICES = 32,
  parameter int EDGES    = 256
) (
  input logic      clk,
  input logic      rst,
  bfs_req_if.sink  req,
  bfs_rsp_if.source rsp
);

  bfs_pkg::cmd_t  cmd;
  bfs_pkg::stat_t stat;
  logic           req_ready;
  logic           rsp_valid;
  logic [1:0]     rsp_status;
  logic [4:0]     rsp_vertex;
  logic           rsp_last;

  // Sequencer.
  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and walk datapath.
  bfs_dp #(
    .VERTICES (VERTICES),
    .EDGES    (EDGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (req.kind),
    .from_vertex (req.from_vertex),
    .to_vertex   (req.to_vertex),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp_valid),
    .rsp_status  (rsp_status),
    .rsp_vertex  (rsp_vertex),
    .rsp_last    (rsp_last)
  );

  // Channel hookup.
  assign req.ready  = req_ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.vertex = rsp_vertex;
  assign rsp.last   = rsp_last;

endmodule
